/* rtl/rbca_pkg.sv */
// Shared types and constants for the reorder buffer with cumulative acknowledgement.
// Used by rbca_slot_table and reorder_buffer_cumulative_ack_core; no dependencies.
package rbca_pkg;

	localparam int SEQ_W = 31;
	localparam int LEN_W = 11;
	localparam int REP_W = 4;

	localparam int TABLE_SLOTS_DEF       = 16;
	localparam int MAX_SEGMENT_BYTES_DEF = 1472;

	// No input produces more results than this
	localparam int RESULT_CAP = 38;
	localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);

	localparam logic [REP_W-1:0] REPEATS_RST = REP_W'(5);

	localparam logic KIND_RELEASE = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_AHEAD = 9'b000000010,
		S_STORE = 9'b000000100,
		S_ACK   = 9'b000001000,
		S_PURGE = 9'b000010000,
		S_REL   = 9'b000100000,
		S_CHAIN = 9'b001000000,
		S_FACK  = 9'b010000000,
		S_REP   = 9'b100000000
	} state_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [LEN_W-1:0] len;
		logic             endf;
	} slot_t;

	typedef struct packed {
		logic write;
		logic inval;
	} tbl_ctl_t;

	typedef struct packed {
		logic  valid;
		logic  match;
		slot_t data;
	} tbl_rd_t;

endpackage

/* rtl/rbca_slot_table.sv */
// Reorder table: per-slot valid flags, stored segment headers and the shared
// sequence comparator used by every scan. Depends on rbca_pkg.
module rbca_slot_table #(
	parameter int TABLE_SLOTS = rbca_pkg::TABLE_SLOTS_DEF,
	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rbca_pkg::tbl_ctl_t             ctl,
	input  logic [IDX_W-1:0]               rd_idx,
	input  logic [rbca_pkg::SEQ_W-1:0]     key,
	input  logic [IDX_W-1:0]               wr_idx,
	input  rbca_pkg::slot_t                wr_data,
	output rbca_pkg::tbl_rd_t              rd
);

	logic [TABLE_SLOTS-1:0] valid_q;
	rbca_pkg::slot_t        slot_q [TABLE_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ctl.write) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (ctl.inval) begin
				valid_q[rd_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.write) begin
			slot_q[wr_idx] <= wr_data;
		end
	end

	always_comb begin
		rd.valid = valid_q[rd_idx];
		rd.data  = slot_q[rd_idx];
		rd.match = (slot_q[rd_idx].seq == key);
	end

endmodule

/* rtl/reorder_buffer_cumulative_ack_core.sv */
// Receiver-side reorder buffer: takes segment headers, stores segments that arrive
// ahead, releases in-order runs and issues cumulative ACKs. Depends on rbca_pkg and
// rbca_slot_table.
//
// One header is taken at a time; in_stall stays high until its last result has been
// loaded into the output register. A single comparator walks the reorder table one
// slot per cycle. A stale, oversized or post-transfer header goes straight to its ACK;
// a header ahead of the expected number is checked against the whole table, stored
// and acknowledged; an in-order header runs a purge scan for a stored copy, then
// releases each segment, with a table scan per chained segment and a closing scan
// that finds no successor (skipped once TABLE_SLOTS segments have chained), then a
// final ACK and, once the end segment is out, final_ack_repeats repeats of it;
// out_stall can hold any result back.
// final_ack_repeats resets to 5 and is written through cfg_wr_en/cfg_wr_data.
module reorder_buffer_cumulative_ack_core #(
	parameter int TABLE_SLOTS       = rbca_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_SEGMENT_BYTES = rbca_pkg::MAX_SEGMENT_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [rbca_pkg::REP_W-1:0]   cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rbca_pkg::SEQ_W-1:0]   seq_number,
	input  logic [rbca_pkg::LEN_W-1:0]   seg_length,
	input  logic                         end_flag,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         result_kind,
	output logic [rbca_pkg::SEQ_W-1:0]   number,
	output logic [rbca_pkg::LEN_W-1:0]   release_length,
	output logic                         end_mark,
	output logic                         dropped,
	output logic                         last_of_run
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [rbca_pkg::LEN_W-1:0] MAX_LEN = rbca_pkg::LEN_W'(MAX_SEGMENT_BYTES);
	localparam logic [rbca_pkg::RES_CNT_W-1:0] CAP_N =
		rbca_pkg::RES_CNT_W'(rbca_pkg::RESULT_CAP);
	localparam logic [rbca_pkg::RES_CNT_W-1:0] CAP_LAST =
		rbca_pkg::RES_CNT_W'(rbca_pkg::RESULT_CAP - 1);

	rbca_pkg::state_t state_q;

	logic [rbca_pkg::SEQ_W-1:0]     seq_q;
	logic [rbca_pkg::LEN_W-1:0]     len_q;
	logic                           end_q;
	logic [rbca_pkg::SEQ_W-1:0]     exp_q;
	logic                           done_q;
	logic [rbca_pkg::REP_W-1:0]     rep_cfg_q;
	logic [IDX_W-1:0]               idx_q;
	logic [CNT_W-1:0]               step_q;
	logic [rbca_pkg::RES_CNT_W-1:0] n_q;
	logic [rbca_pkg::REP_W-1:0]     k_q;
	logic                           hit_found_q;
	logic [IDX_W-1:0]               hit_idx_q;
	logic                           free_found_q;
	logic [IDX_W-1:0]               free_idx_q;
	logic                           ack_end_q;
	logic                           ack_drop_q;

	logic                         out_valid_q;
	logic                         res_kind_q;
	logic [rbca_pkg::SEQ_W-1:0]   res_num_q;
	logic [rbca_pkg::LEN_W-1:0]   res_len_q;
	logic                         res_end_q;
	logic                         res_drop_q;
	logic                         res_last_q;

	rbca_pkg::tbl_ctl_t           tbl_ctl;
	rbca_pkg::tbl_rd_t            tbl_rd;
	rbca_pkg::slot_t              tbl_wr_data;
	logic [rbca_pkg::SEQ_W-1:0]   tbl_key;
	logic [IDX_W-1:0]             tbl_wr_idx;

	logic                         accept;
	logic                         out_free;
	logic                         cap_hit;
	logic                         at_cap_edge;
	logic                         scan_last;
	logic                         slot_hit;
	logic                         go;
	logic                         emit;
	logic                         e_req;
	logic                         e_kind;
	logic [rbca_pkg::SEQ_W-1:0]   e_num;
	logic [rbca_pkg::LEN_W-1:0]   e_len;
	logic                         e_end;
	logic                         e_drop;
	logic                         e_last;

	assign accept      = in_valid && (state_q == rbca_pkg::S_IDLE);
	assign in_stall    = (state_q != rbca_pkg::S_IDLE);
	assign out_free    = !out_valid_q || !out_stall;
	assign cap_hit     = (n_q == CAP_N);
	assign at_cap_edge = (n_q == CAP_LAST);
	assign scan_last   = (idx_q == LAST_IDX);
	assign slot_hit    = tbl_rd.valid && tbl_rd.match;
	// Past the result cap the walk carries on silently
	assign go          = cap_hit || out_free;
	assign emit        = e_req && out_free && !cap_hit;

	assign tbl_key        = (state_q == rbca_pkg::S_AHEAD) ? seq_q : exp_q;
	assign tbl_wr_idx     = hit_found_q ? hit_idx_q : free_idx_q;
	assign tbl_wr_data    = '{seq: seq_q, len: len_q, endf: end_q};
	assign tbl_ctl.write  = (state_q == rbca_pkg::S_STORE) && (hit_found_q || free_found_q);
	assign tbl_ctl.inval  = ((state_q == rbca_pkg::S_PURGE) || (state_q == rbca_pkg::S_CHAIN))
		&& slot_hit;

	rbca_slot_table #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.rd_idx  (idx_q),
		.key     (tbl_key),
		.wr_idx  (tbl_wr_idx),
		.wr_data (tbl_wr_data),
		.rd      (tbl_rd)
	);

	always_comb begin
		e_req  = 1'b0;
		e_kind = rbca_pkg::KIND_ACK;
		e_num  = exp_q;
		e_len  = '0;
		e_end  = 1'b0;
		e_drop = 1'b0;
		e_last = 1'b0;
		unique case (state_q)
			rbca_pkg::S_ACK: begin
				e_req  = 1'b1;
				e_end  = ack_end_q;
				e_drop = ack_drop_q;
				e_last = 1'b1;
			end
			rbca_pkg::S_REL: begin
				e_req  = 1'b1;
				e_kind = rbca_pkg::KIND_RELEASE;
				e_num  = seq_q;
				e_len  = len_q;
				e_end  = end_q;
				e_last = at_cap_edge;
			end
			rbca_pkg::S_FACK: begin
				e_req  = 1'b1;
				e_end  = done_q;
				e_last = !done_q || (rep_cfg_q == '0) || at_cap_edge;
			end
			rbca_pkg::S_REP: begin
				e_req  = 1'b1;
				e_end  = 1'b1;
				e_last = (k_q == rep_cfg_q - rbca_pkg::REP_W'(1)) || at_cap_edge;
			end
			default: begin
				e_req = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_cfg_q <= rbca_pkg::REPEATS_RST;
		end else if (cfg_wr_en) begin
			rep_cfg_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rbca_pkg::S_IDLE;
			exp_q        <= '0;
			done_q       <= 1'b0;
			idx_q        <= '0;
			step_q       <= '0;
			n_q          <= '0;
			k_q          <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			ack_end_q    <= 1'b0;
			ack_drop_q   <= 1'b0;
		end else begin
			if (emit) begin
				n_q <= n_q + rbca_pkg::RES_CNT_W'(1);
			end
			unique case (state_q)
				rbca_pkg::S_IDLE: begin
					if (accept) begin
						n_q          <= '0;
						idx_q        <= '0;
						step_q       <= '0;
						k_q          <= '0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						if (seg_length > MAX_LEN) begin
							ack_end_q  <= done_q;
							ack_drop_q <= 1'b1;
							state_q    <= rbca_pkg::S_ACK;
						end else if (done_q) begin
							ack_end_q  <= 1'b1;
							ack_drop_q <= 1'b0;
							state_q    <= rbca_pkg::S_ACK;
						end else if (seq_number > exp_q) begin
							state_q <= rbca_pkg::S_AHEAD;
						end else if (seq_number == exp_q) begin
							state_q <= rbca_pkg::S_PURGE;
						end else begin
							ack_end_q  <= 1'b0;
							ack_drop_q <= 1'b0;
							state_q    <= rbca_pkg::S_ACK;
						end
					end
				end
				rbca_pkg::S_AHEAD: begin
					// First matching slot wins, else first free slot
					if (slot_hit && !hit_found_q) begin
						hit_found_q <= 1'b1;
						hit_idx_q   <= idx_q;
					end
					if (!tbl_rd.valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_q;
					end
					if (scan_last) begin
						idx_q   <= '0;
						state_q <= rbca_pkg::S_STORE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				rbca_pkg::S_STORE: begin
					ack_end_q  <= 1'b0;
					ack_drop_q <= !(hit_found_q || free_found_q);
					state_q    <= rbca_pkg::S_ACK;
				end
				rbca_pkg::S_ACK: begin
					if (go) begin
						state_q <= rbca_pkg::S_IDLE;
					end
				end
				rbca_pkg::S_PURGE: begin
					if (scan_last) begin
						idx_q   <= '0;
						state_q <= rbca_pkg::S_REL;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				rbca_pkg::S_REL: begin
					if (go) begin
						exp_q  <= exp_q + rbca_pkg::SEQ_W'(len_q);
						done_q <= done_q | end_q;
						idx_q  <= '0;
						if (step_q == CNT_W'(TABLE_SLOTS)) begin
							state_q <= rbca_pkg::S_FACK;
						end else begin
							state_q <= rbca_pkg::S_CHAIN;
						end
					end
				end
				rbca_pkg::S_CHAIN: begin
					if (slot_hit) begin
						step_q  <= step_q + CNT_W'(1);
						idx_q   <= '0;
						state_q <= rbca_pkg::S_REL;
					end else if (scan_last) begin
						idx_q   <= '0;
						state_q <= rbca_pkg::S_FACK;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				rbca_pkg::S_FACK: begin
					if (go) begin
						if (done_q && (rep_cfg_q != '0) && !at_cap_edge && !cap_hit) begin
							state_q <= rbca_pkg::S_REP;
						end else begin
							state_q <= rbca_pkg::S_IDLE;
						end
					end
				end
				rbca_pkg::S_REP: begin
					if (go) begin
						k_q <= k_q + rbca_pkg::REP_W'(1);
						if (e_last || cap_hit) begin
							state_q <= rbca_pkg::S_IDLE;
						end
					end
				end
				default: begin
					state_q <= rbca_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Capture the header on transfer; load the successor when the chain walk finds it
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q <= seq_number;
			len_q <= seg_length;
			end_q <= end_flag;
		end else if ((state_q == rbca_pkg::S_CHAIN) && slot_hit) begin
			seq_q <= tbl_rd.data.seq;
			len_q <= tbl_rd.data.len;
			end_q <= tbl_rd.data.endf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_kind_q <= e_kind;
			res_num_q  <= e_num;
			res_len_q  <= e_len;
			res_end_q  <= e_end;
			res_drop_q <= e_drop;
			res_last_q <= e_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = res_kind_q;
	assign number         = res_num_q;
	assign release_length = res_len_q;
	assign end_mark       = res_end_q;
	assign dropped        = res_drop_q;
	assign last_of_run    = res_last_q;

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("transfer done flag cleared");

	a_exp_only_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != rbca_pkg::S_REL) |=> $stable(exp_q))
		else $error("expected number moved outside a release");

	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CAP_N)
		else $error("result count past cap");

	a_table_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(tbl_ctl.write && tbl_ctl.inval))
		else $error("table write and invalidate in one cycle");

endmodule
